// File: rtl/sioe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sioe_pkg
// Shared sizes, command codes and word layouts of the SPI I/O expander
// command engine.
// ----------------------------------------------------------------------------
package sioe_pkg;

    // Fitted resources.
    localparam int NUM_PINS    = 11;
    localparam int NUM_SAMPLES = 7;
    localparam int NUM_PWM     = 4;

    // Address width of the sample store (depth NUM_SAMPLES).
    localparam int SMP_AW = 3;

    // Event kinds carried in tuser.
    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // High-nibble command groups.
    localparam logic [3:0] GRP_DIR_CLR = 4'h0;
    localparam logic [3:0] GRP_DIR_SET = 4'h1;
    localparam logic [3:0] GRP_OUT_CLR = 4'h2;
    localparam logic [3:0] GRP_OUT_SET = 4'h3;
    localparam logic [3:0] GRP_PIN_RD  = 4'h4;
    localparam logic [3:0] GRP_SMP_RD  = 4'h5;

    // Full command bytes and range bounds.
    localparam logic [7:0] CMD_PWM_OFF  = 8'h60;
    localparam logic [7:0] CMD_PWM_SET  = 8'h64;
    localparam logic [7:0] CMD_PWM_END  = 8'h6C;
    localparam logic [7:0] MODE_SPLIT   = 8'h68;
    localparam logic [7:0] CMD_PWM_LOAD = 8'h6E;
    localparam logic [7:0] CMD_PWM_CLR  = 8'h6F;
    localparam logic [7:0] CMD_ID       = 8'hFF;

    localparam logic [7:0] ID_BYTE = 8'hAC;

    // PWM mode codes written by the single-channel set commands.
    localparam logic [1:0] MODE_LOW  = 2'd1;
    localparam logic [1:0] MODE_HIGH = 2'd2;

    // Trailing byte counts.
    localparam logic [2:0] TRAIL_NONE = 3'd0;
    localparam logic [2:0] TRAIL_ONE  = 3'd1;
    localparam logic [2:0] TRAIL_TWO  = 3'd2;
    localparam logic [2:0] TRAIL_LOAD = 3'd5;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 72;

    typedef logic [NUM_PINS-1:0] t_pins;
    typedef logic [9:0]          t_sample;

endpackage

// File: rtl/spi_io_expander_command_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_io_expander_command_engine
// Byte-wise SPI slave command decoder for an eleven-pin I/O expander with
// four PWM channels and a seven-entry converter sample store.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                         Contents
// s_axis    in   s_axis_tvalid / s_axis_tready     one SPI byte or one sample
// m_axis    out  m_axis_tvalid / m_axis_tready     reply byte and latch state
//
// Every accepted input word produces exactly one output word in the next cycle.
// A new word can be accepted on every clock edge unless m_axis stalls; the
// decode is combinational logic from the input port to the state registers.
// The state registers themselves form the output register, so an input word
// is only taken while the output is empty or being drained on the same edge.
// A stall on m_axis holds s_axis_tready low until the pending word is taken.
// Reset (i_rst_n low, synchronous) clears all latches, duties, modes, the
// sample store and the command sequencer; no clearing pass is needed.
// ----------------------------------------------------------------------------
module spi_io_expander_command_engine
    import sioe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] rx_byte, [18:8] pin_levels, [21:19] sample_channel,
    // [31:22] sample_value
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] operation
    input  logic                  s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] reply_byte, [18:8] pin_direction, [29:19] pin_output,
    // [37:30] duty_a, [45:38] duty_b, [53:46] duty_c, [61:54] duty_d,
    // [69:62] pwm_modes, [71:70] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // Input word fields.
    logic [7:0]        rx_byte;
    t_pins             pin_levels;
    logic [2:0]        sample_channel;
    t_sample           sample_value;
    logic              in_acc;

    assign rx_byte        = s_axis_tdata[7:0];
    assign pin_levels     = s_axis_tdata[18:8];
    assign sample_channel = s_axis_tdata[21:19];
    assign sample_value   = s_axis_tdata[31:22];

    // Command sequencer and latches. These registers also hold the
    // payload of the output word.
    logic [2:0]  r_idx,   n_idx;
    logic [2:0]  r_tc,    n_tc;
    logic [7:0]  r_cmd,   n_cmd;
    t_pins       r_dir,   n_dir;
    t_pins       r_out,   n_out;
    logic [7:0]  r_duty   [4];
    logic [7:0]  n_duty   [4];
    logic [7:0]  r_mode,  n_mode;
    logic [7:0]  r_reply, n_reply;
    t_sample     r_smp    [NUM_SAMPLES];
    logic        r_m_valid;

    // The output is free when empty or drained on this edge.
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;

    // Byte decode. On the command byte the command is taken straight from
    // the input; on trailing bytes the stored command and count apply.
    always_comb begin
        logic [3:0]  hi;
        logic [3:0]  lo;
        t_pins       pin_bit;
        logic [7:0]  reply;
        logic [1:0]  ch;
        logic [2:0]  load_ch;
        t_sample     smp;

        n_cmd  = (r_idx == 3'd0) ? rx_byte : r_cmd;
        n_tc   = (r_idx == 3'd0) ? TRAIL_NONE : r_tc;
        n_dir  = r_dir;
        n_out  = r_out;
        n_mode = r_mode;
        for (int i = 0; i < 4; i++) begin
            n_duty[i] = r_duty[i];
        end
        reply   = 8'd0;
        hi      = n_cmd[7:4];
        lo      = n_cmd[3:0];
        ch      = lo[1:0];
        load_ch = r_idx - 3'd1;
        pin_bit = ({4'd0, lo} < 8'(NUM_PINS)) ? (t_pins'(1) << lo) : '0;
        smp     = r_smp[lo[SMP_AW-1:0]];

        if (hi <= GRP_OUT_SET && {4'd0, lo} < 8'(NUM_PINS)) begin
            case (hi)
                GRP_DIR_CLR: n_dir = r_dir & ~pin_bit;
                GRP_DIR_SET: n_dir = r_dir | pin_bit;
                GRP_OUT_CLR: n_out = r_out & ~pin_bit;
                default:     n_out = r_out | pin_bit;
            endcase
        end else if (hi == GRP_PIN_RD && {4'd0, lo} < 8'(NUM_PINS)) begin
            n_tc = TRAIL_ONE;
            if (r_idx == 3'd0) begin
                reply = {7'd0, pin_levels[lo]};
            end
        end else if (hi == GRP_SMP_RD && {4'd0, lo} < 8'(NUM_SAMPLES)) begin
            n_tc = TRAIL_TWO;
            if (r_idx == 3'd0) begin
                reply = {6'd0, smp[9:8]};
            end else if (r_idx == 3'd1) begin
                reply = smp[7:0];
            end
        end else if (n_cmd >= CMD_PWM_OFF && n_cmd < CMD_PWM_SET) begin
            if ({2'd0, ch} < 4'(NUM_PWM)) begin
                n_duty[ch]          = 8'd0;
                n_mode[2*ch +: 2]   = 2'd0;
            end
        end else if (n_cmd >= CMD_PWM_SET && n_cmd < CMD_PWM_END) begin
            n_tc = TRAIL_ONE;
            if (r_idx == 3'd1 && {2'd0, ch} < 4'(NUM_PWM)) begin
                n_duty[ch]        = rx_byte;
                n_mode[2*ch +: 2] = (n_cmd >= MODE_SPLIT) ? MODE_LOW : MODE_HIGH;
            end
        end else if (n_cmd == CMD_PWM_LOAD) begin
            n_tc = TRAIL_LOAD;
            if (r_idx >= 3'd1 && r_idx <= 3'd4) begin
                if ({1'b0, load_ch} < 4'(NUM_PWM)) begin
                    n_duty[load_ch[1:0]] = rx_byte;
                end
            end else if (r_idx == TRAIL_LOAD) begin
                n_mode = rx_byte;
            end
        end else if (n_cmd == CMD_PWM_CLR) begin
            for (int i = 0; i < 4; i++) begin
                n_duty[i] = 8'd0;
            end
            n_mode = 8'd0;
        end else if (n_cmd == CMD_ID) begin
            n_tc = TRAIL_ONE;
            if (r_idx == 3'd0) begin
                reply = ID_BYTE;
            end
        end

        n_idx   = (r_idx < n_tc) ? (r_idx + 3'd1) : 3'd0;
        n_reply = (n_tc == TRAIL_NONE) ? 8'd0 : reply;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_idx     <= 3'd0;
            r_tc      <= 3'd0;
            r_cmd     <= 8'd0;
            r_dir     <= '0;
            r_out     <= '0;
            r_mode    <= 8'd0;
            r_reply   <= 8'd0;
            for (int i = 0; i < 4; i++) begin
                r_duty[i] <= 8'd0;
            end
            for (int i = 0; i < NUM_SAMPLES; i++) begin
                r_smp[i] <= '0;
            end
        end else begin
            if (in_acc) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            if (in_acc && s_axis_tuser == OP_BYTE) begin
                r_idx   <= n_idx;
                r_tc    <= n_tc;
                r_cmd   <= n_cmd;
                r_dir   <= n_dir;
                r_out   <= n_out;
                r_mode  <= n_mode;
                r_reply <= n_reply;
                for (int i = 0; i < 4; i++) begin
                    r_duty[i] <= n_duty[i];
                end
            end

            // Samples for channels beyond the store are dropped.
            if (in_acc && s_axis_tuser == OP_SAMPLE
                && {1'b0, sample_channel} < 4'(NUM_SAMPLES)) begin
                r_smp[sample_channel[SMP_AW-1:0]] <= sample_value;
            end
        end
    end

    assign m_axis_tdata = {2'b00, r_mode, r_duty[3], r_duty[2], r_duty[1], r_duty[0],
                           r_out, r_dir, r_reply};

    // The sequencer never runs past the longest command.
    a_idx_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= TRAIL_LOAD && r_idx <= r_tc)
        else $error("byte index beyond trailing count");

    // Mid-command, a trailing count must be in force.
    a_tc_mid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 3'd0 |-> r_tc != TRAIL_NONE)
        else $error("trailing byte expected with no trailing count");

    // A converter sample never disturbs the held reply or the sequencer.
    a_sample_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && s_axis_tuser == OP_SAMPLE
        |=> r_reply == $past(r_reply) && r_idx == $past(r_idx))
        else $error("sample event changed the command state");

    // The PWM clear command zeroes every duty and mode.
    a_pwm_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && s_axis_tuser == OP_BYTE && r_idx == 3'd0
        && s_axis_tdata[7:0] == CMD_PWM_CLR
        |=> r_mode == 8'd0 && r_duty[0] == 8'd0 && r_duty[1] == 8'd0
            && r_duty[2] == 8'd0 && r_duty[3] == 8'd0)
        else $error("PWM clear left state behind");

endmodule
